### design/trsc_pkg.sv
// Shared types and constants for the tree record stream checker.
`default_nettype none

package trsc_pkg;

  // Width of the configuration bus address.
  localparam int unsigned PADDR_W = 5;

  // Deepest directory nesting allowed; a directory at this depth may not open a child.
  localparam logic [7:0] MAX_DEPTH = 8'd255;

  // Record size constants, in bytes.
  localparam logic [63:0] ENTRY_MIN_SIZE = 64'd29;
  localparam logic [63:0] ENTRY_FIXED_SIZE = 64'd28;
  localparam logic [63:0] HDR_SIZE = 64'd16;

  // Register reset values.
  localparam logic [23:0] MAGIC_RST = 24'd789997;
  localparam logic [7:0] CODE_STX_RST = 8'd0;
  localparam logic [7:0] CODE_ETX_RST = 8'd1;
  localparam logic [7:0] CODE_SDIR_RST = 8'd2;
  localparam logic [7:0] CODE_EDIR_RST = 8'd3;
  localparam logic [7:0] CODE_ENTRY_RST = 8'd4;
  localparam logic [7:0] CODE_FDATA_RST = 8'd5;

  // Result event codes.
  localparam logic [2:0] EV_HEADER = 3'd0;
  localparam logic [2:0] EV_RECORD = 3'd1;
  localparam logic [2:0] EV_NAME = 3'd2;
  localparam logic [2:0] EV_DATA = 3'd3;
  localparam logic [2:0] EV_ERROR = 3'd4;
  localparam logic [2:0] EV_DONE = 3'd5;
  localparam logic [2:0] EV_IDLE = 3'd6;

  // Configuration register contents.
  typedef struct packed {
    logic [23:0] magic;
    logic [7:0]  code_stx;
    logic [7:0]  code_etx;
    logic [7:0]  code_sdir;
    logic [7:0]  code_edir;
    logic [7:0]  code_entry;
    logic [7:0]  code_fdata;
  } cfg_t;

  // Input beat.
  typedef struct packed {
    logic [7:0] stream_byte;
    logic       end_of_input;
  } in_t;

  // Result beat.
  typedef struct packed {
    logic [2:0] event_res;
    logic [2:0] record_kind;
    logic [7:0] depth_now;
    logic [7:0] payload_byte;
    logic [1:0] entry_kind;
    logic [2:0] error_code;
  } out_t;

endpackage

`default_nettype wire

### design/tree_record_stream_checker.sv
// Top level of the byte-serial directory-tree record stream checker.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------
//   in      | in        | in_valid / in_stall     | trsc_pkg::in_t (1 byte)
//   out     | out       | out_valid / out_stall   | trsc_pkg::out_t (1 event)
//   cfg     | in        | psel/penable/pready     | 7 registers, 32-bit data
//
// One byte is accepted per cycle while in_stall is low; its result passes
// through the input register and then the result register around the parser.
// Reset is synchronous; the valid, state and configuration registers take
// their defaults at once and no clearing pass follows.
// While out_stall holds a result, one more beat waits in the input register;
// in_stall rises only when both registers are full and the result is stalled.
`default_nettype none

module tree_record_stream_checker (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  trsc_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output trsc_pkg::out_t                    out_data,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [trsc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready
);

  trsc_pkg::cfg_t cfg;
  trsc_pkg::in_t  in_beat_r;
  trsc_pkg::out_t out_beat_r;
  trsc_pkg::out_t result;
  logic           in_vld_r;
  logic           out_vld_r;
  logic           advance;
  logic           in_take;

  // A held beat moves on whenever the result register is free or draining.
  assign advance = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_take = in_valid && !in_stall;
  assign out_valid = out_vld_r;
  assign out_data = out_beat_r;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_beat_r <= in_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_beat_r <= result;
    end
  end

  trsc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  trsc_parse u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .beat   (in_beat_r),
    .cfg    (cfg),
    .result (result)
  );

endmodule

`default_nettype wire

### design/trsc_cfg.sv
// APB register block holding the magic word and the record type codes.
`default_nettype none

module trsc_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [trsc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  output trsc_pkg::cfg_t                    cfg
);

  // Register indexes, one word apart.
  localparam logic [2:0] REG_MAGIC = 3'd0;
  localparam logic [2:0] REG_STX = 3'd1;
  localparam logic [2:0] REG_ETX = 3'd2;
  localparam logic [2:0] REG_SDIR = 3'd3;
  localparam logic [2:0] REG_EDIR = 3'd4;
  localparam logic [2:0] REG_ENTRY = 3'd5;
  localparam logic [2:0] REG_FDATA = 3'd6;

  trsc_pkg::cfg_t cfg_r;
  logic [2:0]     reg_idx;
  logic           wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg = cfg_r;

  // Register writes; addresses past the last register are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.magic <= trsc_pkg::MAGIC_RST;
      cfg_r.code_stx <= trsc_pkg::CODE_STX_RST;
      cfg_r.code_etx <= trsc_pkg::CODE_ETX_RST;
      cfg_r.code_sdir <= trsc_pkg::CODE_SDIR_RST;
      cfg_r.code_edir <= trsc_pkg::CODE_EDIR_RST;
      cfg_r.code_entry <= trsc_pkg::CODE_ENTRY_RST;
      cfg_r.code_fdata <= trsc_pkg::CODE_FDATA_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MAGIC: cfg_r.magic <= pwdata[23:0];
        REG_STX:   cfg_r.code_stx <= pwdata[7:0];
        REG_ETX:   cfg_r.code_etx <= pwdata[7:0];
        REG_SDIR:  cfg_r.code_sdir <= pwdata[7:0];
        REG_EDIR:  cfg_r.code_edir <= pwdata[7:0];
        REG_ENTRY: cfg_r.code_entry <= pwdata[7:0];
        REG_FDATA: cfg_r.code_fdata <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    unique case (reg_idx)
      REG_MAGIC: prdata = {8'd0, cfg_r.magic};
      REG_STX:   prdata = {24'd0, cfg_r.code_stx};
      REG_ETX:   prdata = {24'd0, cfg_r.code_etx};
      REG_SDIR:  prdata = {24'd0, cfg_r.code_sdir};
      REG_EDIR:  prdata = {24'd0, cfg_r.code_edir};
      REG_ENTRY: prdata = {24'd0, cfg_r.code_entry};
      REG_FDATA: prdata = {24'd0, cfg_r.code_fdata};
      default:   prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

### design/trsc_parse.sv
// Grammar state machine: parser state and the next-state logic for one byte.
`default_nettype none

module trsc_parse (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step,
  input  trsc_pkg::in_t       beat,
  input  trsc_pkg::cfg_t      cfg,
  output trsc_pkg::out_t      result
);

  // Parse phases.
  localparam logic [3:0] PH_TX_START = 4'd0;
  localparam logic [3:0] PH_DIR_START = 4'd1;
  localparam logic [3:0] PH_DIR_BODY = 4'd2;
  localparam logic [3:0] PH_FILE = 4'd3;
  localparam logic [3:0] PH_TX_END = 4'd4;
  localparam logic [3:0] PH_ENTRY_TAIL = 4'd5;
  localparam logic [3:0] PH_NAME = 4'd6;
  localparam logic [3:0] PH_DATA = 4'd7;
  localparam logic [3:0] PH_DONE = 4'd8;
  localparam logic [3:0] PH_ERROR = 4'd9;

  // Record kinds.
  localparam logic [2:0] K_STX = 3'd0;
  localparam logic [2:0] K_ETX = 3'd1;
  localparam logic [2:0] K_SDIR = 3'd2;
  localparam logic [2:0] K_EDIR = 3'd3;
  localparam logic [2:0] K_ENTRY = 3'd4;
  localparam logic [2:0] K_FDATA = 3'd5;

  // Entry mode classes.
  localparam logic [1:0] MODE_OTHER = 2'd0;
  localparam logic [1:0] MODE_REG = 2'd1;
  localparam logic [1:0] MODE_DIR = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_MAGIC = 3'd1;
  localparam logic [2:0] ERR_TYPE = 3'd2;
  localparam logic [2:0] ERR_DEPTH = 3'd3;
  localparam logic [2:0] ERR_SIZE = 3'd4;
  localparam logic [2:0] ERR_DSIZE = 3'd5;
  localparam logic [2:0] ERR_EARLY = 3'd6;
  localparam logic [2:0] ERR_OVFL = 3'd7;

  logic [3:0]  phase_r, phase_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [2:0]  type_r, type_nxt;
  logic [7:0]  depth_r, depth_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] exp_r, exp_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [2:0]  err_r, err_nxt;

  logic [7:0]  b;
  logic [63:0] acc_sh;
  logic [63:0] acc_new;
  logic [63:0] rem_dec;
  logic [63:0] exp16;
  logic [7:0]  magic_b;
  logic        kind_ok;
  logic [2:0]  kind;
  logic        fail_en;
  logic [2:0]  fail_code;
  logic [2:0]  ev;
  logic [7:0]  payload;

  assign b = beat.stream_byte;
  assign acc_sh = {acc_r[55:0], b};
  assign rem_dec = rem_r - 64'd1;
  assign exp16 = exp_r + trsc_pkg::HDR_SIZE;

  // Expected magic byte for the current header position.
  always_comb begin
    case (idx_r[1:0])
      2'd0:    magic_b = cfg.magic[23:16];
      2'd1:    magic_b = cfg.magic[15:8];
      default: magic_b = cfg.magic[7:0];
    endcase
  end

  // Type byte decode; inside a directory end-directory wins over entry.
  always_comb begin
    kind_ok = 1'b0;
    kind = K_STX;
    unique case (phase_r)
      PH_TX_START: begin
        kind_ok = (b == cfg.code_stx);
        kind = K_STX;
      end
      PH_DIR_START: begin
        kind_ok = (b == cfg.code_sdir);
        kind = K_SDIR;
      end
      PH_DIR_BODY: begin
        if (b == cfg.code_edir) begin
          kind_ok = 1'b1;
          kind = K_EDIR;
        end else begin
          kind_ok = (b == cfg.code_entry);
          kind = K_ENTRY;
        end
      end
      PH_FILE: begin
        kind_ok = (b == cfg.code_fdata);
        kind = K_FDATA;
      end
      PH_TX_END: begin
        kind_ok = (b == cfg.code_etx);
        kind = K_ETX;
      end
      default: ;
    endcase
  end

  // Next-state logic for one stream byte.
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt = idx_r;
    type_nxt = type_r;
    depth_nxt = depth_r;
    acc_nxt = acc_r;
    rem_nxt = rem_r;
    exp_nxt = exp_r;
    mode_nxt = mode_r;
    err_nxt = err_r;
    fail_en = 1'b0;
    fail_code = ERR_MAGIC;
    ev = trsc_pkg::EV_HEADER;
    payload = 8'd0;
    acc_new = acc_sh;

    if (phase_r == PH_DONE) begin
      ev = trsc_pkg::EV_IDLE;
    end else if (phase_r >= PH_ERROR) begin
      ev = trsc_pkg::EV_ERROR;
    end else if (beat.end_of_input) begin
      fail_en = 1'b1;
      fail_code = ERR_EARLY;
    end else begin
      unique case (phase_r) inside
        // Entry mode and content size fields.
        PH_ENTRY_TAIL: begin
          acc_new = (idx_r == 4'd0 || idx_r == 4'd4) ? {56'd0, b} : acc_sh;
          acc_nxt = acc_new;
          if (idx_r == 4'd3) begin
            case (acc_new[15:12])
              4'h8:    mode_nxt = MODE_REG;
              4'h4:    mode_nxt = MODE_DIR;
              default: mode_nxt = MODE_OTHER;
            endcase
          end
          if (idx_r >= 4'd11) begin
            exp_nxt = acc_new;
            idx_nxt = 4'd0;
            phase_nxt = PH_NAME;
            ev = trsc_pkg::EV_RECORD;
          end else begin
            idx_nxt = idx_r + 4'd1;
          end
        end

        // Name bytes; the last one decides what follows the entry.
        PH_NAME: begin
          rem_nxt = rem_dec;
          ev = trsc_pkg::EV_NAME;
          payload = b;
          if (rem_dec == 64'd0) begin
            if (mode_r == MODE_REG) begin
              phase_nxt = PH_FILE;
            end else if (mode_r == MODE_DIR) begin
              if (depth_r >= trsc_pkg::MAX_DEPTH) begin
                fail_en = 1'b1;
                fail_code = ERR_OVFL;
              end else begin
                depth_nxt = depth_r + 8'd1;
                phase_nxt = PH_DIR_START;
              end
            end else begin
              phase_nxt = PH_DIR_BODY;
            end
          end
        end

        // File content bytes.
        PH_DATA: begin
          rem_nxt = rem_dec;
          ev = trsc_pkg::EV_DATA;
          payload = b;
          if (rem_dec == 64'd0) begin
            phase_nxt = PH_DIR_BODY;
          end
        end

        // Record header: magic, type, depth and size.
        PH_TX_START, PH_DIR_START, PH_DIR_BODY, PH_FILE, PH_TX_END: begin
          if (idx_r < 4'd3) begin
            if (b != magic_b) begin
              fail_en = 1'b1;
              fail_code = ERR_MAGIC;
            end else begin
              idx_nxt = idx_r + 4'd1;
            end
          end else if (idx_r == 4'd3) begin
            if (!kind_ok) begin
              fail_en = 1'b1;
              fail_code = ERR_TYPE;
            end else begin
              type_nxt = kind;
              idx_nxt = 4'd4;
            end
          end else begin
            acc_new = (idx_r == 4'd4 || idx_r == 4'd8) ? {56'd0, b} : acc_sh;
            acc_nxt = acc_new;
            if (idx_r == 4'd7 && acc_new[31:0] != {24'd0, depth_r}) begin
              fail_en = 1'b1;
              fail_code = ERR_DEPTH;
            end else if (idx_r == 4'd15) begin
              idx_nxt = 4'd0;
              if (type_r == K_ENTRY) begin
                if (acc_new < trsc_pkg::ENTRY_MIN_SIZE) begin
                  fail_en = 1'b1;
                  fail_code = ERR_SIZE;
                end else begin
                  rem_nxt = acc_new - trsc_pkg::ENTRY_FIXED_SIZE;
                  phase_nxt = PH_ENTRY_TAIL;
                end
              end else if (type_r == K_FDATA) begin
                // A size below the header or a wrapped sum can never match.
                if (acc_new < trsc_pkg::HDR_SIZE || acc_new != exp16) begin
                  fail_en = 1'b1;
                  fail_code = ERR_DSIZE;
                end else begin
                  rem_nxt = exp_r;
                  phase_nxt = (exp_r == 64'd0) ? PH_DIR_BODY : PH_DATA;
                  ev = trsc_pkg::EV_RECORD;
                end
              end else if (acc_new != trsc_pkg::HDR_SIZE) begin
                fail_en = 1'b1;
                fail_code = ERR_SIZE;
              end else begin
                ev = trsc_pkg::EV_RECORD;
                case (type_r)
                  K_STX: begin
                    depth_nxt = 8'd1;
                    phase_nxt = PH_DIR_START;
                  end
                  K_SDIR: begin
                    phase_nxt = PH_DIR_BODY;
                  end
                  K_EDIR: begin
                    if (depth_r <= 8'd1) begin
                      depth_nxt = 8'd0;
                      phase_nxt = PH_TX_END;
                    end else begin
                      depth_nxt = depth_r - 8'd1;
                      phase_nxt = PH_DIR_BODY;
                    end
                  end
                  default: begin
                    phase_nxt = PH_DONE;
                    ev = trsc_pkg::EV_DONE;
                  end
                endcase
              end
            end else begin
              idx_nxt = idx_r + 4'd1;
            end
          end
        end

        default: ;
      endcase
    end

    // The first error sticks and the parser stops.
    if (fail_en) begin
      phase_nxt = PH_ERROR;
      err_nxt = fail_code;
      ev = trsc_pkg::EV_ERROR;
      payload = 8'd0;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TX_START;
      idx_r <= 4'd0;
      type_r <= K_STX;
      depth_r <= 8'd0;
      acc_r <= 64'd0;
      rem_r <= 64'd0;
      exp_r <= 64'd0;
      mode_r <= MODE_OTHER;
      err_r <= 3'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      idx_r <= idx_nxt;
      type_r <= type_nxt;
      depth_r <= depth_nxt;
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
      exp_r <= exp_nxt;
      mode_r <= mode_nxt;
      err_r <= err_nxt;
    end
  end

  // Result fields reflect the state after this byte.
  always_comb begin
    result.event_res = ev;
    result.record_kind = type_nxt;
    result.depth_now = depth_nxt;
    result.payload_byte = payload;
    result.entry_kind = mode_nxt;
    result.error_code = err_nxt;
  end

endmodule

`default_nettype wire

### design/trsc_chk.sv
// Port-level checks on the result stream of the record stream checker.
`default_nettype none

module trsc_chk (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input trsc_pkg::out_t out_data
);

  // A stalled result beat stays and holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Error events carry a nonzero code, and every other event carries none.
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.event_res == trsc_pkg::EV_ERROR) ==
                   (out_data.error_code != 3'd0)))
    else $error("error code does not match the event");

  // Only name and data events pass a byte through.
  a_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_res != trsc_pkg::EV_NAME &&
    out_data.event_res != trsc_pkg::EV_DATA |-> out_data.payload_byte == 8'd0)
    else $error("payload byte on a non-payload event");

  // The stream can only finish back at the top level.
  a_done_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_res == trsc_pkg::EV_DONE ||
                  out_data.event_res == trsc_pkg::EV_IDLE) |->
    out_data.depth_now == 8'd0)
    else $error("stream finished at nonzero depth");

endmodule

bind tree_record_stream_checker trsc_chk u_trsc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
